### rtl/cabb_pkg.sv
// ----------------------------------------------------------------------------
// cabb_pkg - circular arc bounding box shared definitions
// Widths, sequencer states, multiplier steps and quadrant helpers.
// ----------------------------------------------------------------------------
package cabb_pkg;

   localparam int COORD_BITS    = 24;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int ROOT_BITS     = COORD_BITS + 2;
   localparam int RAD_BITS      = 2 * ROOT_BITS;
   localparam int REM_BITS      = ROOT_BITS + 3;
   localparam int REL_BITS      = ROOT_BITS;
   localparam int BOX_BITS      = 27;
   localparam int ITER_BITS     = $clog2(ROOT_BITS);
   localparam int REQ_DATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((4 * BOX_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT,
      ST_BOX,
      ST_DONE
   } state_type;

   // operand pair issued to the shared multiplier
   typedef enum logic [2:0] {
      MUL_XX,
      MUL_YY,
      MUL_YX,
      MUL_XY,
      MUL_CMP
   } mul_step_type;

   typedef enum logic [2:0] {
      QUAD_NONE,
      QUAD_1,
      QUAD_2,
      QUAD_3,
      QUAD_4
   } quad_type;

   function automatic quad_type quad_of(logic signed [DIFF_BITS-1:0] x,
                                        logic signed [DIFF_BITS-1:0] y);
      quad_type q;
      if (x >= 0 && y > 0) begin
         q = QUAD_1;
      end else if (x < 0 && y >= 0) begin
         q = QUAD_2;
      end else if (x <= 0 && y < 0) begin
         q = QUAD_3;
      end else if (x > 0 && y <= 0) begin
         q = QUAD_4;
      end else begin
         q = QUAD_NONE;
      end
      return q;
   endfunction

   // counter-clockwise neighbor
   function automatic quad_type quad_next(quad_type q);
      quad_type n;
      case (q)
         QUAD_1:  n = QUAD_2;
         QUAD_2:  n = QUAD_3;
         QUAD_3:  n = QUAD_4;
         default: n = QUAD_1;
      endcase
      return n;
   endfunction

endpackage

### rtl/circular_arc_bounding_box_core.sv
// ----------------------------------------------------------------------------
// circular_arc_bounding_box_core - bounding box of a counter-clockwise arc
// Shared multiplier and bit-serial square root under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one arc per word: start, end and center points
//   as signed Q16.8 coordinates. The rsp_ channel returns one word per arc:
//   the box corners xmin, ymin, xmax, ymax (27-bit signed, same units) in
//   tdata and the end-at-center flag in tuser.
//   A word is taken when tvalid and tready are both high.
// Sequence:
//   An accepted arc passes through the one signed 25x25 multiplier (two
//   squares, two cross products), then the restoring square root (one
//   root bit per cycle), then a step that grows the box by the crossed
//   extremes and a step that adds the center back before rsp_tvalid.
//   req_tready is high only while the sequencer is idle, so a new arc is
//   not taken before the last one has left the sequencer.
// Reset and stall:
//   Synchronous active-high reset returns the sequencer to idle and drops
//   rsp_tvalid. The result sits in its own output register, so a new arc is
//   accepted while a finished box waits for rsp_tready; the sequencer holds
//   in its last state only if a second box is ready before the first leaves.
// ----------------------------------------------------------------------------
module circular_arc_bounding_box_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, end_x, end_y, center_x, center_y
   input  logic [cabb_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // box_xmin, box_ymin, box_xmax, box_ymax, zero pad
   output logic [cabb_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // end_at_center
   output logic                                  rsp_tuser
);
   import cabb_pkg::*;

   // control state
   state_type                     state_ff, state_in;
   mul_step_type                  mstep_ff, mstep_in;
   logic [ITER_BITS-1:0]          iter_ff, iter_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // arc relative to its center
   logic signed [DIFF_BITS-1:0]   x0_ff, x0_in, y0_ff, y0_in;
   logic signed [DIFF_BITS-1:0]   x1_ff, x1_in, y1_ff, y1_in;
   logic signed [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic                          endc_ff, endc_in;

   // multiplier and root datapath
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]   cross_ff, cross_in;
   logic [PROD_BITS-1:0]          sq_ff, sq_in;
   logic                          long_ff, long_in;
   logic [RAD_BITS-1:0]           rad_ff, rad_in;
   logic [REM_BITS-1:0]           rem_ff, rem_in;
   logic [ROOT_BITS-1:0]          root_ff, root_in;

   // box relative to the center, then the output word
   logic signed [REL_BITS-1:0]    xmin_ff, xmin_in, ymin_ff, ymin_in;
   logic signed [REL_BITS-1:0]    xmax_ff, xmax_in, ymax_ff, ymax_in;
   logic signed [BOX_BITS-1:0]    oxmin_ff, oxmin_in, oymin_ff, oymin_in;
   logic signed [BOX_BITS-1:0]    oxmax_ff, oxmax_in, oymax_ff, oymax_in;
   logic                          oendc_ff, oendc_in;

   // input fields
   logic signed [COORD_BITS-1:0]  sx, sy, ex, ey, cx, cy;

   // shared multiplier operands
   logic signed [DIFF_BITS-1:0]   mul_a, mul_b;

   // root step
   logic [REM_BITS-1:0]           rem_sh, trial;
   logic                          root_ge;

   // box step
   logic signed [REL_BITS-1:0]    r_pos, r_neg;
   logic signed [REL_BITS-1:0]    ex0, ex1, ey0, ey1;
   logic signed [REL_BITS-1:0]    bxmin, bymin, bxmax, bymax;
   quad_type                      q_start, q_end, q_walk;
   logic                          grow, full;
   logic                          pass_n, pass_w, pass_s, pass_e;

   assign sx = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign sy = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign ex = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign ey = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign cx = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign cy = req_tdata[5*COORD_BITS +: COORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({oymax_ff, oxmax_ff, oymin_ff, oxmin_ff});
   assign rsp_tuser  = oendc_ff;

   // shared multiplier: one product per cycle, registered
   always_comb begin
      case (mstep_ff)
         MUL_YY: begin
            mul_a = y0_ff;
            mul_b = y0_ff;
         end
         MUL_YX: begin
            mul_a = y1_ff;
            mul_b = x0_ff;
         end
         MUL_XY: begin
            mul_a = x1_ff;
            mul_b = y0_ff;
         end
         default: begin
            mul_a = x0_ff;
            mul_b = x0_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // restoring square root: bring down two radicand bits, try root*4+1
   assign rem_sh  = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial   = REM_BITS'({root_ff, 2'b01});
   assign root_ge = (rem_sh >= trial);

   // box growth from the radius and the quadrants passed
   always_comb begin
      r_pos = REL_BITS'({1'b0, root_ff[ROOT_BITS-2:0]});
      r_neg = -r_pos;
      ex0   = REL_BITS'(x0_ff);
      ex1   = REL_BITS'(x1_ff);
      ey0   = REL_BITS'(y0_ff);
      ey1   = REL_BITS'(y1_ff);
      bxmin = (ex0 < ex1) ? ex0 : ex1;
      bxmax = (ex0 > ex1) ? ex0 : ex1;
      bymin = (ey0 < ey1) ? ey0 : ey1;
      bymax = (ey0 > ey1) ? ey0 : ey1;

      q_start = quad_of(x0_ff, y0_ff);
      q_end   = quad_of(x1_ff, y1_ff);
      grow    = (root_ff != '0) && !endc_ff;
      full    = (q_start == q_end) && long_ff;

      // walk counter-clockwise from the start quadrant, mark each extreme
      pass_n = 1'b0;
      pass_w = 1'b0;
      pass_s = 1'b0;
      pass_e = 1'b0;
      q_walk = q_start;
      for (int n = 0; n < 4; n++) begin
         if (q_walk != q_end) begin
            case (q_walk)
               QUAD_1:  pass_n = 1'b1;
               QUAD_2:  pass_w = 1'b1;
               QUAD_3:  pass_s = 1'b1;
               QUAD_4:  pass_e = 1'b1;
               default: ;
            endcase
            q_walk = quad_next(q_walk);
         end
      end
   end

   // sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      mstep_in     = mstep_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      endc_in      = endc_ff;
      cross_in     = cross_ff;
      sq_in        = sq_ff;
      long_in      = long_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      xmin_in      = xmin_ff;
      ymin_in      = ymin_ff;
      xmax_in      = xmax_ff;
      ymax_in      = ymax_ff;
      oxmin_in     = oxmin_ff;
      oymin_in     = oymin_ff;
      oxmax_in     = oxmax_ff;
      oymax_in     = oymax_ff;
      oendc_in     = oendc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x0_in    = DIFF_BITS'(sx) - DIFF_BITS'(cx);
               y0_in    = DIFF_BITS'(sy) - DIFF_BITS'(cy);
               x1_in    = DIFF_BITS'(ex) - DIFF_BITS'(cx);
               y1_in    = DIFF_BITS'(ey) - DIFF_BITS'(cy);
               cx_in    = cx;
               cy_in    = cy;
               endc_in  = (ex == cx) && (ey == cy);
               mstep_in = MUL_XX;
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            mstep_in = mul_step_type'(mstep_ff + 3'd1);
            case (mstep_ff)
               MUL_YY: sq_in    = prod_ff;
               MUL_YX: sq_in    = sq_ff + PROD_BITS'(unsigned'(prod_ff));
               MUL_XY: cross_in = prod_ff;
               MUL_CMP: begin
                  // long way round when start-to-end cross product is negative
                  long_in  = (cross_ff < prod_ff);
                  rad_in   = RAD_BITS'(sq_ff);
                  rem_in   = '0;
                  root_in  = '0;
                  iter_in  = ITER_BITS'(ROOT_BITS - 1);
                  state_in = ST_ROOT;
               end
               default: ;
            endcase
         end

         ST_ROOT: begin
            rem_in  = root_ge ? (rem_sh - trial) : rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], root_ge};
            rad_in  = rad_ff << 2;
            if (iter_ff == '0) begin
               state_in = ST_BOX;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end

         ST_BOX: begin
            xmin_in  = (grow && (full || pass_w) && bxmin > r_neg) ? r_neg : bxmin;
            ymin_in  = (grow && (full || pass_s) && bymin > r_neg) ? r_neg : bymin;
            xmax_in  = (grow && (full || pass_e) && bxmax < r_pos) ? r_pos : bxmax;
            ymax_in  = (grow && (full || pass_n) && bymax < r_pos) ? r_pos : bymax;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               oxmin_in     = BOX_BITS'(xmin_ff) + BOX_BITS'(cx_ff);
               oymin_in     = BOX_BITS'(ymin_ff) + BOX_BITS'(cy_ff);
               oxmax_in     = BOX_BITS'(xmax_ff) + BOX_BITS'(cx_ff);
               oymax_in     = BOX_BITS'(ymax_ff) + BOX_BITS'(cy_ff);
               oendc_in     = endc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mstep_ff     <= MUL_XX;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      endc_ff  <= endc_in;
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
      sq_ff    <= sq_in;
      long_ff  <= long_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      xmin_ff  <= xmin_in;
      ymin_ff  <= ymin_in;
      xmax_ff  <= xmax_in;
      ymax_ff  <= ymax_in;
      oxmin_ff <= oxmin_in;
      oymin_ff <= oymin_in;
      oxmax_ff <= oxmax_in;
      oymax_ff <= oymax_in;
      oendc_ff <= oendc_in;
   end

endmodule

### tb/sv/circular_arc_bounding_box_checker.sv
// ----------------------------------------------------------------------------
// circular_arc_bounding_box_checker - scoreboard for the arc bounding box core
// Watches the req_ and rsp_ channels and predicts the box for every arc word
// taken. Compares each returned box word with the oldest prediction.
// ----------------------------------------------------------------------------
module circular_arc_bounding_box_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // start_x, start_y, end_x, end_y, center_x, center_y
   input  logic [cabb_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // box_xmin, box_ymin, box_xmax, box_ymax, zero pad
   input  logic [cabb_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // end_at_center
   input  logic                                rsp_tuser,
   output int                                  fail_count,
   output int                                  boxes_pending,
   output int                                  arcs_seen,
   output int                                  boxes_checked,
   output int                                  center_flags,
   output int                                  full_circles
);
   timeunit 1ns;
   timeprecision 1ps;
   import cabb_pkg::*;

   localparam int CB       = COORD_BITS;
   localparam int BB       = BOX_BITS;
   localparam int ROOT_TOP = CB + 1;

   typedef struct packed {
      logic [3:0][BB-1:0] corner;   // xmin, ymin, xmax, ymax from index 0
      logic               at_center;
      logic               full_circle;
   } arc_box_type;

   arc_box_type box_fifo [$];
   string       corner_name [4] = '{"xmin", "ymin", "xmax", "ymax"};

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   function automatic longint coord_at(input logic [REQ_DATA_BITS-1:0] word,
                                       input int idx);
      logic signed [CB-1:0] c;
      c = word[idx*CB +: CB];
      return longint'(c);
   endfunction

   function automatic quad_type quadrant(input longint x, input longint y);
      if (x >= 0 && y > 0) return QUAD_1;
      if (x < 0 && y >= 0) return QUAD_2;
      if (x <= 0 && y < 0) return QUAD_3;
      if (x > 0 && y <= 0) return QUAD_4;
      return QUAD_NONE;
   endfunction

   function automatic quad_type ccw_next(input quad_type q);
      case (q)
         QUAD_1:  return QUAD_2;
         QUAD_2:  return QUAD_3;
         QUAD_3:  return QUAD_4;
         default: return QUAD_1;
      endcase
   endfunction

   function automatic arc_box_type bound_arc(input logic [REQ_DATA_BITS-1:0] word);
      longint      cx, cy, x0, y0, x1, y1;
      longint      lo_x, lo_y, hi_x, hi_y;
      longint      rad, cand, dist2;
      longint      fin [4];
      quad_type    q_at, q_end;
      arc_box_type b;
      cx = coord_at(word, 4);
      cy = coord_at(word, 5);
      x0 = coord_at(word, 0) - cx;
      y0 = coord_at(word, 1) - cy;
      x1 = coord_at(word, 2) - cx;
      y1 = coord_at(word, 3) - cy;
      lo_x = (x0 < x1) ? x0 : x1;
      lo_y = (y0 < y1) ? y0 : y1;
      hi_x = (x0 > x1) ? x0 : x1;
      hi_y = (y0 > y1) ? y0 : y1;
      b.at_center   = (x1 == 0 && y1 == 0);
      b.full_circle = 1'b0;
      // floor root of the start distance squared, one bit at a time
      dist2 = x0 * x0 + y0 * y0;
      rad = 0;
      for (int bit_pos = ROOT_TOP; bit_pos >= 0; bit_pos--) begin
         cand = rad | (longint'(1) << bit_pos);
         if (cand * cand <= dist2) rad = cand;
      end
      if (rad > 0 && !b.at_center) begin
         q_at  = quadrant(x0, y0);
         q_end = quadrant(x1, y1);
         if (q_at == q_end && y1 * x0 < x1 * y0) begin
            // long way round inside one quadrant: whole circle
            b.full_circle = 1'b1;
            if (lo_x > -rad) lo_x = -rad;
            if (lo_y > -rad) lo_y = -rad;
            if (hi_x < rad) hi_x = rad;
            if (hi_y < rad) hi_y = rad;
         end else begin
            for (int n = 0; n < 4 && q_at != q_end; n++) begin
               case (q_at)
                  QUAD_1:  if (hi_y < rad) hi_y = rad;
                  QUAD_2:  if (lo_x > -rad) lo_x = -rad;
                  QUAD_3:  if (lo_y > -rad) lo_y = -rad;
                  QUAD_4:  if (hi_x < rad) hi_x = rad;
                  default: ;
               endcase
               q_at = ccw_next(q_at);
            end
         end
      end
      fin[0] = lo_x + cx;
      fin[1] = lo_y + cy;
      fin[2] = hi_x + cx;
      fin[3] = hi_y + cy;
      for (int i = 0; i < 4; i++) begin
         b.corner[i] = fin[i][BB-1:0];
      end
      return b;
   endfunction

   always @(posedge clock) begin : watch
      arc_box_type        want;
      logic [3:0][BB-1:0] got;
      if (reset) begin
         box_fifo.delete();
         fail_count    = 0;
         arcs_seen     = 0;
         boxes_checked = 0;
         center_flags  = 0;
         full_circles  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[4*BB-1:0];
            if (box_fifo.size() == 0) begin
               report_mismatch($sformatf("box word with no arc outstanding, tdata=%h",
                                         rsp_tdata));
            end else begin
               want = box_fifo.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got[i] !== want.corner[i]) begin
                     report_mismatch($sformatf("box %0d %s: got %0d, expected %0d",
                                               boxes_checked, corner_name[i],
                                               $signed(got[i]), $signed(want.corner[i])));
                  end
               end
               if (rsp_tuser !== want.at_center) begin
                  report_mismatch($sformatf("box %0d end_at_center: got %b, expected %b",
                                            boxes_checked, rsp_tuser, want.at_center));
               end
               boxes_checked++;
               center_flags += int'(want.at_center);
               full_circles += int'(want.full_circle);
            end
         end
         if (req_tvalid && req_tready) begin
            box_fifo.push_back(bound_arc(req_tdata));
            arcs_seen++;
         end
      end
      boxes_pending = box_fifo.size();
   end

endmodule

### tb/sv/circular_arc_bounding_box_core_tb.sv
// ----------------------------------------------------------------------------
// circular_arc_bounding_box_core_tb - testbench top for the arc bounding box
// Sends directed and random arcs in bursts, stalls the result side, and
// leaves prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module circular_arc_bounding_box_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cabb_pkg::*;

   localparam int CB          = COORD_BITS;
   localparam int RANDOM_ARCS = 1030;
   localparam int HOLD_AFTER  = 400;     // arcs sent before the long result stall
   localparam int HOLD_CYCLES = 500;
   localparam int TAIL_CYCLES = 40;      // a bit over one arc's latency
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAXC        = 8388607;
   localparam int MINC        = -8388608;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   int fail_count, boxes_pending, arcs_seen, boxes_checked, center_flags, full_circles;
   int arcs_sent = 0;
   int cycles    = 0;

   logic [REQ_DATA_BITS-1:0] directed_arcs [$];

   always #5 clock = ~clock;

   circular_arc_bounding_box_core u_top (.*);

   circular_arc_bounding_box_checker u_checker (.*);

   // Pack one arc word, start_x in the lowest bits up to center_y.
   function automatic logic [REQ_DATA_BITS-1:0] pack_arc(
      input int sx, input int sy, input int ex, input int ey, input int cx, input int cy);
      return {cy[CB-1:0], cx[CB-1:0], ey[CB-1:0], ex[CB-1:0], sy[CB-1:0], sx[CB-1:0]};
   endfunction

   // Same, with start and end given as offsets from the center.
   function automatic logic [REQ_DATA_BITS-1:0] pack_rel(
      input int cx, input int cy, input int sdx, input int sdy, input int edx, input int edy);
      return pack_arc(cx + sdx, cy + sdy, cx + edx, cy + edy, cx, cy);
   endfunction

   // Offset from the center: zero, tiny (axis and quadrant edges) up to full range.
   function automatic int rand_offset();
      int mag;
      case ($urandom_range(0, 5))
         0:       mag = 0;
         1:       mag = $urandom_range(0, 8);
         2:       mag = $urandom_range(0, 255);
         3:       mag = $urandom_range(0, 65535);
         4:       mag = $urandom_range(0, (1 << 20) - 1);
         default: mag = $urandom_range(0, 1 << 23);
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic int rand_center();
      return $urandom_range(0, 1) ? int'($urandom) : rand_offset();
   endfunction

   function automatic logic [REQ_DATA_BITS-1:0] rand_arc();
      int mode, cx, cy, sdx, sdy, edx, edy;
      mode = $urandom_range(0, 15);
      cx   = rand_center();
      cy   = rand_center();
      sdx  = rand_offset();
      sdy  = rand_offset();
      edx  = rand_offset();
      edy  = rand_offset();
      // raw words toggle every coordinate bit
      if (mode <= 2) return pack_arc($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
      case (mode)
         3: begin
            edx = 0;
            edy = 0;
         end
         4: begin
            sdx = 0;
            sdy = 0;
         end
         5: begin
            // end near the start: often the same quadrant, short or long way round
            edx = sdx + int'($urandom_range(0, 8)) - 4;
            edy = sdy + int'($urandom_range(0, 8)) - 4;
         end
         6: begin
            if ($urandom_range(0, 1)) edx = 0;
            else edy = 0;
         end
         7: begin
            if ($urandom_range(0, 1)) sdx = 0;
            else sdy = 0;
         end
         default: ;
      endcase
      return pack_rel(cx, cy, sdx, sdy, edx, edy);
   endfunction

   // Watchdog: end the run if the core hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d boxes still due", cycles, boxes_pending);
         $display("FAIL circular_arc_bounding_box_core");
         $finish;
      end
   end

   // Sender: directed arcs first, then random ones, in bursts with gaps.
   initial begin : drive_arcs
      logic [REQ_DATA_BITS-1:0] word;
      int burst, gap, total;
      // extremes of the coordinate range
      directed_arcs.push_back(pack_arc(0, 0, 0, 0, 0, 0));
      directed_arcs.push_back(pack_arc(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
      directed_arcs.push_back(pack_arc(MINC, MINC, MINC, MINC, MINC, MINC));
      directed_arcs.push_back(pack_arc(MAXC, MAXC, MAXC, MINC, MINC, MINC));
      directed_arcs.push_back(pack_arc(MINC, MINC, MAXC, MINC, MAXC, MAXC));
      // each quadrant step and multi-step crossings, radius 1000
      directed_arcs.push_back(pack_rel(1000, -2000, 600, 800, -800, 600));
      directed_arcs.push_back(pack_rel(1000, -2000, -800, 600, -600, -800));
      directed_arcs.push_back(pack_rel(1000, -2000, -600, -800, 800, -600));
      directed_arcs.push_back(pack_rel(1000, -2000, 800, -600, 600, 800));
      directed_arcs.push_back(pack_rel(0, 0, 600, 800, -600, -800));
      directed_arcs.push_back(pack_rel(0, 0, -800, 600, 600, 800));
      // same quadrant: short way, long way (full circle) in Q1 and Q3
      directed_arcs.push_back(pack_rel(-5000, 7000, 800, 600, 600, 800));
      directed_arcs.push_back(pack_rel(-5000, 7000, 600, 800, 800, 600));
      directed_arcs.push_back(pack_rel(-5000, 7000, -600, -800, -800, -600));
      // start at center, end at center
      directed_arcs.push_back(pack_rel(300, 300, 0, 0, 300, 400));
      directed_arcs.push_back(pack_rel(300, 300, 600, 800, 0, 0));
      // points on the axes
      directed_arcs.push_back(pack_rel(0, 0, 1000, 0, 0, 1000));
      directed_arcs.push_back(pack_rel(0, 0, 0, 1000, -1000, 0));
      directed_arcs.push_back(pack_rel(0, 0, -1000, 0, 0, -1000));
      directed_arcs.push_back(pack_rel(0, 0, 0, -1000, 1000, 0));
      // radius taken from the start only, and root rounding
      directed_arcs.push_back(pack_rel(0, 0, 3, 4, -100, -100));
      directed_arcs.push_back(pack_rel(0, 0, 1, 1, -1, 1));
      // start equals end
      directed_arcs.push_back(pack_rel(0, 0, 600, 800, 600, 800));
      total = directed_arcs.size() + RANDOM_ARCS;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (arcs_sent < total) begin
         // now and then a long burst with no gaps at all
         burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         repeat (burst) begin
            if (arcs_sent < total) begin
               word = (arcs_sent < directed_arcs.size()) ? directed_arcs[arcs_sent]
                                                         : rand_arc();
               req_tdata  <= word;
               req_tvalid <= 1'b1;
               // hold the word until the core takes it
               @(posedge clock);
               while (!req_tready) @(posedge clock);
               arcs_sent++;
            end
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // drain: advance one edge so the last prediction is queued, then wait it out
      @(posedge clock);
      while (boxes_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d boxes from %0d arcs (%0d directed, rest random).",
               boxes_checked, arcs_seen, directed_arcs.size());
      $display("Covered %0d end-at-center arcs, %0d full-circle arcs, one %0d-cycle result stall.",
               center_flags, full_circles, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("PASS circular_arc_bounding_box_core");
      end else begin
         $display("FAIL circular_arc_bounding_box_core");
      end
      $finish;
   end

   // Receiver: pick a new stall pattern whenever the current span runs out; once,
   // hold off long enough for the core to fill and drop req_tready.
   initial begin : drain_boxes
      int  span, mode, hold_left;
      bit  hold_done;
      logic ready;
      span      = 0;
      mode      = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && arcs_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            case (mode)
               0:       ready = 1'b1;
               1:       ready = 1'($urandom_range(0, 1));
               2:       ready = ($urandom_range(0, 5) == 0);
               default: ready = span[2];
            endcase
         end
         rsp_tready <= ready;
      end
   end

endmodule
